FILE: hw/rtl/armw_pkg.sv
`default_nettype none
package armw_pkg;

    // Field widths of one request and one response word
    localparam int CMD_W    = 4;
    localparam int SIZE_W   = 2;
    localparam int ADDR_W   = 13;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;

    // Byte address bits above the in-word byte offset
    localparam int WORD_ADDR_W = ADDR_W - 3;

    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 72;

    // Atomic operation codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_AND  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_OR   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_XOR  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INC  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DEC  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_EXCH = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MIN  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_MAX  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_CAS  = 4'd9;

    // Response status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CMD    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture an accepted request
        logic rd;      // read the addressed store word
        logic finish;  // modify, write back and load the response register
    } t_dp_cmd;

endpackage
`default_nettype wire

FILE: hw/rtl/atomic_rmw_memory_unit.sv
// A request is captured, reads the store, then is modified and written back as the
// response register loads; a new request enters only while idle or in that step,
// as the single store port reads then writes; a stalled response stops that step.
// Reset: synchronous, active low; clears the controller and response valid.
// Store contents are not cleared: no clearing pass, words are undefined until written.
`default_nettype none
module atomic_rmw_memory_unit
    import armw_pkg::*;
#(
    parameter int STORE_WORDS = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata, from bit 0: command[3:0], size_code[5:4], byte_address[18:6],
    // operand_value[82:19], swap_value[146:83], zero pad to 152
    input  wire  [IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // tdata, from bit 0: old_value[63:0], status[65:64], zero pad to 72
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_dp_cmd             w_cmd;
    logic [DATA_W-1:0]   w_old_value;
    logic [STATUS_W-1:0] w_status;

    // Controller: sequences capture, store read, then modify and write back.
    armw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    // Datapath: request registers, word store, operation unit and the
    // response register that lets the next request enter while a result waits.
    armw_dpath #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_cmd           (w_cmd),
        .i_command       (i_s_axis_tdata[3:0]),
        .i_size_code     (i_s_axis_tdata[5:4]),
        .i_byte_address  (i_s_axis_tdata[18:6]),
        .i_operand_value (i_s_axis_tdata[82:19]),
        .i_swap_value    (i_s_axis_tdata[146:83]),
        .o_old_value     (w_old_value),
        .o_status        (w_status)
    );

    // Pack the response word; pad the upper bits with zeros.
    assign o_m_axis_tdata = {{(OUT_TDATA_W - DATA_W - STATUS_W){1'b0}}, w_status, w_old_value};

    // A captured request always reads the store in the next cycle.
    a_load_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> w_cmd.rd)
        else $error("store read did not follow request capture");

    // Capture never overlaps the read of the previous request.
    a_no_load_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd |-> !w_cmd.load)
        else $error("request captured during store read");

    // Reads are never issued in two consecutive cycles.
    a_no_double_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rd |=> !w_cmd.rd)
        else $error("back to back store reads");

    // A write-back step always presents a response in the next cycle.
    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_m_axis_tvalid)
        else $error("write-back step produced no response word");

endmodule
`default_nettype wire

FILE: hw/rtl/armw_ctrl.sv
`default_nettype none
module armw_ctrl
    import armw_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  wire     i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_finish;
    logic   w_accept;

    // Finish only when the response register is free or being drained
    assign w_finish   = (r_state == S_WRITE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE) || w_finish;
    assign w_accept   = i_in_valid && o_in_ready;

    assign o_cmd.load   = w_accept;
    assign o_cmd.rd     = (r_state == S_READ);
    assign o_cmd.finish = w_finish;
    assign o_out_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (w_finish) n_state = w_accept ? S_READ : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = r_out_valid;
        priority if (w_finish) n_out_valid = 1'b1;
        else if (i_out_ready)  n_out_valid = 1'b0;
        else                   n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/armw_dpath.sv
`default_nettype none
module armw_dpath
    import armw_pkg::*;
#(
    parameter int STORE_WORDS = 1024
) (
    input  wire                 i_clk,
    input  t_dp_cmd             i_cmd,
    input  wire  [CMD_W-1:0]    i_command,
    input  wire  [SIZE_W-1:0]   i_size_code,
    input  wire  [ADDR_W-1:0]   i_byte_address,
    input  wire  [DATA_W-1:0]   i_operand_value,
    input  wire  [DATA_W-1:0]   i_swap_value,
    output logic [DATA_W-1:0]   o_old_value,
    output logic [STATUS_W-1:0] o_status
);

    localparam int IDX_W   = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam bit WRAP    = STORE_WORDS < (1 << WORD_ADDR_W);
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP   = ((1 << RECIP_SHIFT) + STORE_WORDS - 1) / STORE_WORDS;
    localparam int RECIP_W = 17;
    localparam int PROD_W  = RECIP_W + WORD_ADDR_W;
    localparam int QUOT_W  = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0]     RECIP_V = RECIP_W'(RECIP);
    localparam logic [WORD_ADDR_W-1:0] MOD_V   = WRAP ? WORD_ADDR_W'(STORE_WORDS)
                                                      : '0;

    logic [DATA_W-1:0] mem [STORE_WORDS];

    logic [CMD_W-1:0]       r_cmd;
    logic [SIZE_W-1:0]      r_size;
    logic [ADDR_W-1:0]      r_addr;
    logic [DATA_W-1:0]      r_opnd;
    logic [DATA_W-1:0]      r_swap;
    logic [QUOT_W-1:0]      r_quot;
    logic [DATA_W-1:0]      r_rdata;
    logic [DATA_W-1:0]      r_old;
    logic [STATUS_W-1:0]    r_status;

    logic [PROD_W-1:0]      w_prod;
    logic [WORD_ADDR_W-1:0] w_word;
    logic [WORD_ADDR_W-1:0] w_rem;
    logic [IDX_W-1:0]       w_idx;
    logic [5:0]             w_shift;
    logic [DATA_W-1:0]      w_mask;
    logic [DATA_W-1:0]      w_a;
    logic [DATA_W-1:0]      w_b;
    logic [DATA_W-1:0]      w_old;
    logic [DATA_W-1:0]      w_nv;
    logic [DATA_W-1:0]      w_merged;
    logic [2:0]             w_align;
    logic                   w_bad_cmd;
    logic                   w_misaligned;
    logic                   w_cas_hit;
    logic                   w_wr_en;

    // Quotient of word address by store depth through a reciprocal
    assign w_prod = PROD_W'(i_byte_address[ADDR_W-1:3]) * PROD_W'(RECIP_V);

    assign w_word = r_addr[ADDR_W-1:3];
    assign w_rem  = w_word - (WORD_ADDR_W'(r_quot) * MOD_V);
    assign w_idx  = WRAP ? IDX_W'(w_rem) : IDX_W'(w_word);

    always_comb begin
        unique case (r_size)
            2'd0:    w_mask = 64'h0000_0000_0000_00FF;
            2'd1:    w_mask = 64'h0000_0000_0000_FFFF;
            2'd2:    w_mask = 64'h0000_0000_FFFF_FFFF;
            default: w_mask = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    end

    assign w_align      = 3'((4'd1 << r_size) - 4'd1);
    assign w_bad_cmd    = r_cmd > CMD_CAS;
    assign w_misaligned = (r_addr[2:0] & w_align) != 3'd0;
    assign w_shift      = {r_addr[2:0], 3'b000};
    assign w_a          = r_opnd & w_mask;
    assign w_b          = r_swap & w_mask;
    assign w_old        = (r_rdata >> w_shift) & w_mask;
    assign w_cas_hit    = w_old == w_a;

    always_comb begin
        unique case (r_cmd)
            CMD_ADD:  w_nv = w_old + w_a;
            CMD_AND:  w_nv = w_old & w_a;
            CMD_OR:   w_nv = w_old | w_a;
            CMD_XOR:  w_nv = w_old ^ w_a;
            CMD_INC:  w_nv = (w_old >= w_a) ? '0 : w_old + 64'd1;
            CMD_DEC:  w_nv = ((w_old == '0) || (w_old > w_a)) ? w_a : w_old - 64'd1;
            CMD_EXCH: w_nv = w_a;
            CMD_MIN:  w_nv = (w_old < w_a) ? w_old : w_a;
            CMD_MAX:  w_nv = (w_old > w_a) ? w_old : w_a;
            default:  w_nv = w_b;
        endcase
    end

    assign w_merged = (r_rdata & ~(w_mask << w_shift)) | ((w_nv & w_mask) << w_shift);
    assign w_wr_en  = i_cmd.finish && !w_bad_cmd && !w_misaligned
                      && ((r_cmd != CMD_CAS) || w_cas_hit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_size <= i_size_code;
            r_addr <= i_byte_address;
            r_opnd <= i_operand_value;
            r_swap <= i_swap_value;
            r_quot <= w_prod[PROD_W-1:RECIP_SHIFT];
        end
        if (i_cmd.finish) begin
            priority if (w_bad_cmd) begin
                r_old    <= '0;
                r_status <= STATUS_BAD_CMD;
            end else if (w_misaligned) begin
                r_old    <= '0;
                r_status <= STATUS_MISALIGNED;
            end else begin
                r_old    <= w_old;
                r_status <= STATUS_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= mem[w_idx];
        if (w_wr_en)  mem[w_idx] <= w_merged;
    end

    assign o_old_value = r_old;
    assign o_status    = r_status;

endmodule
`default_nettype wire

FILE: test/tb_atomic_rmw_memory_unit.sv
`default_nettype none
module tb_atomic_rmw_memory_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import armw_pkg::*;

    localparam int STORE_WORDS  = 1024;
    localparam int RANDOM_ITEMS = 720;
    localparam int QUIET_TAIL   = 120;       // last random words sent with no idling
    localparam int CYCLE_LIMIT  = 200_000;

    // Command codes above CMD_CAS are reserved and must be rejected
    localparam logic [CMD_W-1:0] CMD_BAD_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 4'd15;

    // Access size codes
    localparam logic [SIZE_W-1:0] SZ_1B = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_2B = 2'd1;
    localparam logic [SIZE_W-1:0] SZ_4B = 2'd2;
    localparam logic [SIZE_W-1:0] SZ_8B = 2'd3;

    // One request word; fixed rows carry a hand-typed response
    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [SIZE_W-1:0]   sz;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   opv;
        logic [DATA_W-1:0]   swv;
        bit                  fixed;
        logic [DATA_W-1:0]   fix_old;
        logic [STATUS_W-1:0] fix_st;
    } t_atomic_req;

    // One awaited response word
    typedef struct {
        logic [DATA_W-1:0]   old;
        logic [STATUS_W-1:0] st;
        bit                  check_old;
    } t_atomic_resp;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the word store, updated in acceptance order
    logic [DATA_W-1:0] mem_mirror [STORE_WORDS];
    t_atomic_resp      expected_loads [$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  quiet       = 1'b0;   // no idling on either side once set

    atomic_rmw_memory_unit #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // tdata, from bit 0: command, size_code, byte_address, operand_value,
        // swap_value, zero pad
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // tdata, from bit 0: old_value, status, zero pad
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mask of the low bytes touched by an access of the given size
    function automatic logic [DATA_W-1:0] lane_bits(input logic [SIZE_W-1:0] sz);
        logic [DATA_W-1:0] mask;
        if (sz == SZ_8B)
            mask = '1;
        else
            mask = (64'd1 << (8 * (1 << sz))) - 64'd1;
        return mask;
    endfunction

    // Predict the response of one request and update the shadow store
    function automatic t_atomic_resp run_atomic(input t_atomic_req r);
        t_atomic_resp      res;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] nv;
        int unsigned       idx;
        int unsigned       sh;
        bit                wr;
        res.old       = '0;
        res.st        = STATUS_DONE;
        res.check_old = 1'b1;
        mask = lane_bits(r.sz);
        a    = r.opv & mask;
        b    = r.swv & mask;
        // An unknown command wins over a bad address
        if (r.cmd > CMD_CAS) begin
            res.st = STATUS_BAD_CMD;
            return res;
        end
        if ((r.addr & ADDR_W'((1 << r.sz) - 1)) != '0) begin
            res.st = STATUS_MISALIGNED;
            return res;
        end
        idx  = (r.addr >> 3) % STORE_WORDS;
        sh   = 8 * r.addr[2:0];
        word = mem_mirror[idx];
        res.old = (word >> sh) & mask;
        wr = 1'b1;
        case (r.cmd)
            CMD_ADD:  nv = res.old + a;
            CMD_AND:  nv = res.old & a;
            CMD_OR:   nv = res.old | a;
            CMD_XOR:  nv = res.old ^ a;
            // Wrapping increment: back to zero once the bound is reached
            CMD_INC:  nv = (res.old >= a) ? '0 : res.old + 64'd1;
            // Clamped decrement: reload the bound from zero or from above it
            CMD_DEC:  nv = (res.old == '0 || res.old > a) ? a : res.old - 64'd1;
            CMD_EXCH: nv = a;
            CMD_MIN:  nv = (res.old < a) ? res.old : a;
            CMD_MAX:  nv = (res.old > a) ? res.old : a;
            default: begin
                // Compare-and-swap: skip the write on a miss
                nv = b;
                wr = (res.old == a);
            end
        endcase
        if (wr)
            mem_mirror[idx] = (word & ~(mask << sh)) | ((nv & mask) << sh);
        return res;
    endfunction

    // Offer one request word, hold it until accepted, then queue its response
    task automatic issue_word(input t_atomic_req r, input bit check_old);
        t_atomic_resp res;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r.swv, r.opv, r.addr, r.sz, r.cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        res = run_atomic(r);
        if (r.fixed) begin
            res.old = r.fix_old;
            res.st  = r.fix_st;
        end
        res.check_old = check_old;
        expected_loads.push_back(res);
    endtask

    // Response side: check each accepted word, then stall in random bursts
    always @(posedge clk) begin : resp_side
        t_atomic_resp want;
        int           stall_left;
        if (rst_n && m_tready && m_tvalid) begin
            if (expected_loads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word %h", m_tdata);
            end else begin
                want = expected_loads.pop_front();
                if ((want.check_old && m_tdata[DATA_W-1:0] !== want.old) ||
                    m_tdata[DATA_W+STATUS_W-1:DATA_W] !== want.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"response mismatch: old_value exp %h got %h,",
                                  " status exp %0d got %0d"},
                                 want.old, m_tdata[DATA_W-1:0], want.st,
                                 m_tdata[DATA_W+STATUS_W-1:DATA_W]);
                end
            end
        end
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (!quiet && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 18);
        m_tready <= (stall_left == 0);
    end

    // Watchdog: end a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_atomic_req       rows [$];
        t_atomic_req       r;
        logic [5:0]        k6;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] cur;
        logic [DATA_W-1:0] pick;
        logic [ADDR_W-1:0] last_addr;
        logic [SIZE_W-1:0] last_sz;
        int                roll;
        int                lane;

        // Hold reset, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Seed 64 working words spread over every address bit. The store is not
        // cleared at reset, so the seeding exchange returns an unknown value: skip
        // the old_value compare on these words only.
        for (int k = 0; k < 64; k++) begin
            k6 = 6'(k);
            r = '{CMD_EXCH, SZ_8B, {k6, k6[3:0], 3'b000}, {$urandom, $urandom}, '0,
                  1'b0, '0, STATUS_DONE};
            issue_word(r, 1'b0);
        end

        // Directed rows: error codes typed in, everything else predicted.
        // Working words used here: word 0 (bytes 0..7), 17 (136..143), 1023 (8184..8191).
        rows.push_back('{CMD_BAD_LO,     SZ_1B, 13'd0,    '0, '0, 1'b1, '0, STATUS_BAD_CMD});
        rows.push_back('{CMD_BAD_HI,     SZ_8B, 13'd8191, '1, '1, 1'b1, '0, STATUS_BAD_CMD});
        rows.push_back('{CMD_W'(CMD_BAD_LO + 1), SZ_2B, 13'd136, '1, '0,
                         1'b1, '0, STATUS_BAD_CMD});
        rows.push_back('{CMD_W'(CMD_BAD_LO + 2), SZ_4B, 13'd4097, '0, '1,
                         1'b1, '0, STATUS_BAD_CMD});
        rows.push_back('{CMD_W'(CMD_BAD_LO + 3), SZ_1B, 13'd8191, '1, '1,
                         1'b1, '0, STATUS_BAD_CMD});
        rows.push_back('{CMD_W'(CMD_BAD_LO + 4), SZ_8B, 13'd0, '1, '0,
                         1'b1, '0, STATUS_BAD_CMD});
        rows.push_back('{CMD_ADD,  SZ_2B, 13'd1,    '1, '0, 1'b1, '0, STATUS_MISALIGNED});
        rows.push_back('{CMD_CAS,  SZ_4B, 13'd8190, '0, '1, 1'b1, '0, STATUS_MISALIGNED});
        rows.push_back('{CMD_EXCH, SZ_8B, 13'd4,    '1, '1, 1'b1, '0, STATUS_MISALIGNED});
        rows.push_back('{CMD_MAX,  SZ_8B, 13'd8191, '1, '1, 1'b1, '0, STATUS_MISALIGNED});
        rows.push_back('{CMD_EXCH, SZ_8B, 13'd0,    '1, '0, 1'b0, '0, STATUS_DONE});
        // Byte add overflows and wraps inside its lane
        rows.push_back('{CMD_ADD,  SZ_1B, 13'd0,    64'd1, '1, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_INC,  SZ_1B, 13'd1,    '1, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_DEC,  SZ_1B, 13'd0,    64'h5a5a_5a5a_5a5a_5aab, '0,
                         1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_EXCH, SZ_8B, 13'd8184, '0, '1, 1'b0, '0, STATUS_DONE});
        // Decrement from zero, from above the bound, then a plain step down
        rows.push_back('{CMD_DEC,  SZ_2B, 13'd8184, 64'd5, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_DEC,  SZ_2B, 13'd8184, 64'd3, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_DEC,  SZ_2B, 13'd8184, 64'd9, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_INC,  SZ_4B, 13'd8188, 64'd0, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_INC,  SZ_4B, 13'd8188, 64'd10, '0, 1'b0, '0, STATUS_DONE});
        // Compare-and-swap hit, then a miss that must leave the lane alone
        rows.push_back('{CMD_CAS,  SZ_4B, 13'd8188, 64'd1, 64'hffff_ffff_1234_5678,
                         1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_CAS,  SZ_4B, 13'd8188, 64'd1, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_MIN,  SZ_8B, 13'd0,    64'h8000_0000_0000_0000, '0,
                         1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_MAX,  SZ_8B, 13'd136,  '1, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_AND,  SZ_4B, 13'd136,  64'hdead_beef_f0f0_0ff0, '0,
                         1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_OR,   SZ_2B, 13'd138,  64'h0123_4567_89ab_cdef, '0,
                         1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_XOR,  SZ_1B, 13'd143,  '1, '0, 1'b0, '0, STATUS_DONE});
        rows.push_back('{CMD_ADD,  SZ_8B, 13'd8184, '1, '0, 1'b0, '0, STATUS_DONE});
        foreach (rows[i])
            issue_word(rows[i], 1'b1);

        // Random part: mostly valid accesses to the working words, with some
        // back-to-back reuse of one lane, plus reserved codes and misalignment
        last_addr = 13'd8184;
        last_sz   = SZ_8B;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            roll    = $urandom_range(0, 99);
            r.sz    = SIZE_W'($urandom_range(0, 3));
            r.opv   = {$urandom, $urandom};
            r.swv   = {$urandom, $urandom};
            r.fixed = 1'b0;
            r.fix_old = '0;
            r.fix_st  = STATUS_DONE;
            if (roll < 7) begin
                r.cmd  = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
                r.addr = ADDR_W'($urandom_range(0, 8191));
            end else if (roll < 14) begin
                r.cmd  = CMD_W'($urandom_range(CMD_ADD, CMD_CAS));
                r.sz   = SIZE_W'($urandom_range(SZ_2B, SZ_8B));
                r.addr = ADDR_W'($urandom_range(0, 8191));
                if ((r.addr & ADDR_W'((1 << r.sz) - 1)) == '0)
                    r.addr[0] = 1'b1;
            end else begin
                r.cmd = CMD_W'($urandom_range(CMD_ADD, CMD_CAS));
                if (roll < 40) begin
                    // Hit the lane just touched to stress read-after-write
                    r.addr = last_addr;
                    r.sz   = last_sz;
                end else begin
                    k6     = 6'($urandom_range(0, 63));
                    lane   = ($urandom_range(0, 7) >> r.sz) << r.sz;
                    r.addr = {k6, k6[3:0], 3'b000} | ADDR_W'(lane);
                end
                last_addr = r.addr;
                last_sz   = r.sz;
                // Steer the operand around the current lane value to reach
                // compare hits and the increment and decrement boundaries
                mask = lane_bits(r.sz);
                cur  = (mem_mirror[(r.addr >> 3) % STORE_WORDS] >> (8 * r.addr[2:0])) & mask;
                case ($urandom_range(0, 5))
                    0: pick = cur;
                    1: pick = cur + 64'd1;
                    2: pick = cur - 64'd1;
                    3: pick = 64'($urandom_range(0, 15));
                    4: pick = $urandom_range(0, 1) ? mask : '0;
                    default: pick = r.opv;
                endcase
                r.opv = (r.opv & ~mask) | (pick & mask);
            end
            issue_word(r, 1'b1);
        end

        // Drain: drop valid, wait for every response, then run on for spare cycles
        s_tvalid <= 1'b0;
        while (expected_loads.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

FILE: atomic_rmw_memory_unit.f
hw/rtl/armw_pkg.sv
hw/rtl/armw_ctrl.sv
hw/rtl/armw_dpath.sv
hw/rtl/atomic_rmw_memory_unit.sv
test/tb_atomic_rmw_memory_unit.sv
